/* design/hfn_pkg.sv */
// Shared types and constants for the heightfield normal pipeline.
`timescale 1ns / 1ps
`default_nettype none
package hfn_pkg;

  localparam int unsigned FIELD_W = 32;  // width of elevation and register fields
  localparam int unsigned DIFF_W  = 34;  // signed axis difference, mirrored side doubled
  localparam int unsigned MAG_W   = 33;  // magnitude of an axis difference
  localparam int unsigned PROD_W  = 65;  // magnitude times a Q16.16 scale
  localparam int unsigned BLEN_W  = 7;   // bit length of a product
  localparam int unsigned SH_W    = 6;   // common normalizing shift
  localparam int unsigned COMP_W  = 31;  // component after normalizing shift
  localparam int unsigned SQ_W    = 62;  // square of one component
  localparam int unsigned SUM_W   = 64;  // sum of three squares
  localparam int unsigned ROOT_W  = 32;  // integer root of the sum
  localparam int unsigned OUT_W   = 16;  // width of one output component
  localparam int unsigned CIDX_W  = 3;   // configuration register index

  typedef enum logic [CIDX_W-1:0] {
    CFG_X_GRAD    = 3'd0,
    CFG_Y_GRAD    = 3'd1,
    CFG_FLAT      = 3'd2,
    CFG_NULL_MARK = 3'd3,
    CFG_NULL_CHK  = 3'd4,
    CFG_ZERO_MSK  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [FIELD_W-1:0]        x_grad;
    logic [FIELD_W-1:0]        y_grad;
    logic [FIELD_W-1:0]        flat;
    logic signed [FIELD_W-1:0] null_mark;
    logic                      null_chk;
    logic                      zero_msk;
  } cfg_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic written;
  } flags_t;

  typedef struct packed {
    logic [COMP_W-1:0] a;
    logic [COMP_W-1:0] b;
    logic [COMP_W-1:0] f;
    flags_t            fl;
  } norm_aux_t;

endpackage
`default_nettype wire

/* design/hfn_front.sv */
// Masking, axis differences, scaling, common normalizing shift and sum of squares.
`timescale 1ns / 1ps
`default_nettype none
module hfn_front import hfn_pkg::*; #(
  parameter int unsigned ELEV_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [FIELD_W-1:0] center_i,
  input  wire logic [FIELD_W-1:0] left_i,
  input  wire logic [FIELD_W-1:0] right_i,
  input  wire logic [FIELD_W-1:0] top_i,
  input  wire logic [FIELD_W-1:0] bottom_i,
  input  wire logic [3:0]         edge_mask_i,
  input  wire cfg_t               cfg_i,
  output logic                    valid_o,
  output logic [SUM_W-1:0]        sumsq_o,
  output norm_aux_t               aux_o
);

  function automatic logic signed [DIFF_W-1:0] axis_diff(
    input logic signed [DIFF_W-1:0] c,
    input logic signed [DIFF_W-1:0] p,
    input logic                     has_p,
    input logic signed [DIFF_W-1:0] m,
    input logic                     has_m
  );
    logic signed [DIFF_W-1:0] res;
    if (has_p && has_m) begin
      res = p - m;
    end else if (has_p) begin
      res = (p - c) <<< 1;
    end else if (has_m) begin
      res = (c - m) <<< 1;
    end else begin
      res = '0;
    end
    return res;
  endfunction

  function automatic logic [BLEN_W-1:0] bit_len(input logic [PROD_W-1:0] v);
    logic [BLEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < PROD_W; i++) begin
      if (v[i]) n = BLEN_W'(i + 1);
    end
    return n;
  endfunction

  // Stage 1: masking and axis differences.
  logic signed [ELEV_BITS-1:0] c_e, l_e, r_e, t_e, b_e;
  logic signed [DIFF_W-1:0]    c_x, l_x, r_x, t_x, b_x, null_x, dx, dy;
  logic [DIFF_W-1:0]           ax, ay;
  logic [3:0]                  mk;
  logic                        c_null;

  always_comb begin
    c_e = center_i[ELEV_BITS-1:0];
    l_e = left_i[ELEV_BITS-1:0];
    r_e = right_i[ELEV_BITS-1:0];
    t_e = top_i[ELEV_BITS-1:0];
    b_e = bottom_i[ELEV_BITS-1:0];
    c_x = DIFF_W'(c_e);
    l_x = DIFF_W'(l_e);
    r_x = DIFF_W'(r_e);
    t_x = DIFF_W'(t_e);
    b_x = DIFF_W'(b_e);
    null_x = DIFF_W'(cfg_i.null_mark);
    mk = edge_mask_i;
    if (cfg_i.null_chk) begin
      if (t_x == null_x) mk[3] = 1'b0;
      if (b_x == null_x) mk[2] = 1'b0;
      if (l_x == null_x) mk[1] = 1'b0;
      if (r_x == null_x) mk[0] = 1'b0;
    end
    if (cfg_i.zero_msk) begin
      if (t_x == '0) mk[3] = 1'b0;
      if (b_x == '0) mk[2] = 1'b0;
      if (l_x == '0) mk[1] = 1'b0;
      if (r_x == '0) mk[0] = 1'b0;
    end
    c_null = cfg_i.null_chk && (c_x == null_x);
    dx = axis_diff(c_x, r_x, mk[0], l_x, mk[1]);
    dy = axis_diff(c_x, b_x, mk[2], t_x, mk[3]);
    ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  end

  logic              vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q, vld7_q;
  logic [MAG_W-1:0]  mx1_q, my1_q;
  flags_t            fl1_q, fl2_q, fl3_q, fl4_q, fl5_q, fl6_q, fl7_q;
  logic [63:0]       pxl2_q, pyl2_q;
  logic              pxh2_q, pyh2_q;
  logic [PROD_W-1:0] pa3_q, pb3_q, pa4_q, pb4_q;
  logic [SH_W-1:0]   sh4_q;
  logic [COMP_W-1:0] a5_q, b5_q, f5_q, a6_q, b6_q, f6_q, a7_q, b7_q, f7_q;
  logic [SQ_W-1:0]   sqa6_q, sqb6_q, sqf6_q;
  logic [SUM_W-1:0]  sum7_q;

  logic [BLEN_W-1:0] blen;
  logic [SH_W-1:0]   sh4_d;

  always_comb begin
    blen = bit_len(pa3_q | pb3_q | PROD_W'(cfg_i.flat));
    sh4_d = (blen > BLEN_W'(COMP_W)) ? SH_W'(blen - BLEN_W'(COMP_W)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
      vld7_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
      vld6_q <= vld5_q;
      vld7_q <= vld6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage 1
      mx1_q         <= ax[MAG_W-1:0];
      my1_q         <= ay[MAG_W-1:0];
      fl1_q.neg_x   <= (dx > 0);
      fl1_q.neg_y   <= (dy < 0);
      fl1_q.written <= !c_null && (mk != 4'b0000);
      // Stage 2: low partial products; the top magnitude bit is folded in next.
      pxl2_q <= mx1_q[31:0] * cfg_i.y_grad;
      pyl2_q <= my1_q[31:0] * cfg_i.x_grad;
      pxh2_q <= mx1_q[MAG_W-1];
      pyh2_q <= my1_q[MAG_W-1];
      fl2_q  <= fl1_q;
      // Stage 3
      pa3_q <= PROD_W'(pxl2_q) + (pxh2_q ? {1'b0, cfg_i.y_grad, 32'd0} : '0);
      pb3_q <= PROD_W'(pyl2_q) + (pyh2_q ? {1'b0, cfg_i.x_grad, 32'd0} : '0);
      fl3_q <= fl2_q;
      // Stage 4
      pa4_q <= pa3_q;
      pb4_q <= pb3_q;
      sh4_q <= sh4_d;
      fl4_q <= fl3_q;
      // Stage 5
      a5_q  <= COMP_W'(pa4_q >> sh4_q);
      b5_q  <= COMP_W'(pb4_q >> sh4_q);
      f5_q  <= COMP_W'(PROD_W'(cfg_i.flat) >> sh4_q);
      fl5_q <= fl4_q;
      // Stage 6
      sqa6_q <= a5_q * a5_q;
      sqb6_q <= b5_q * b5_q;
      sqf6_q <= f5_q * f5_q;
      a6_q   <= a5_q;
      b6_q   <= b5_q;
      f6_q   <= f5_q;
      fl6_q  <= fl5_q;
      // Stage 7
      sum7_q <= SUM_W'(sqa6_q) + SUM_W'(sqb6_q) + SUM_W'(sqf6_q);
      a7_q   <= a6_q;
      b7_q   <= b6_q;
      f7_q   <= f6_q;
      fl7_q  <= fl6_q;
    end
  end

  assign valid_o  = vld7_q;
  assign sumsq_o  = sum7_q;
  assign aux_o.a  = a7_q;
  assign aux_o.b  = b7_q;
  assign aux_o.f  = f7_q;
  assign aux_o.fl = fl7_q;

endmodule
`default_nettype wire

/* design/hfn_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module hfn_sqrt import hfn_pkg::*; #(
  parameter int unsigned AUX_W = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [SUM_W-1:0] v_i,
  input  wire logic [AUX_W-1:0] aux_i,
  output logic                  valid_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [AUX_W-1:0]      aux_o
);

  logic             vld_q [ROOT_W];
  logic [SUM_W-1:0] v_q   [ROOT_W];
  logic [SUM_W-1:0] r_q   [ROOT_W];
  logic [AUX_W-1:0] aux_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
    logic             vld_in;
    logic [SUM_W-1:0] v_in, r_in, trial;
    logic [AUX_W-1:0] aux_in;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign v_in   = v_i;
      assign r_in   = '0;
      assign aux_in = aux_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign v_in   = v_q[k-1];
      assign r_in   = r_q[k-1];
      assign aux_in = aux_q[k-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_in >= trial) begin
          v_q[k] <= v_in - trial;
          r_q[k] <= (r_in >> 1) + BIT;
        end else begin
          v_q[k] <= v_in;
          r_q[k] <= r_in >> 1;
        end
        aux_q[k] <= aux_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = r_q[ROOT_W-1][ROOT_W-1:0];
  assign aux_o   = aux_q[ROOT_W-1];

endmodule
`default_nettype wire

/* design/hfn_div.sv */
// Three-lane pipelined restoring divider: rounded component over length.
`timescale 1ns / 1ps
`default_nettype none
module hfn_div import hfn_pkg::*; #(
  parameter int unsigned FRAC_BITS = 15,
  parameter int unsigned AUX_W     = 3
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [2:0][COMP_W-1:0]       m_i,
  input  wire logic [ROOT_W-1:0]            len_i,
  input  wire logic [AUX_W-1:0]             aux_i,
  output logic                              valid_o,
  output logic [2:0][FRAC_BITS:0]           q_o,
  output logic [AUX_W-1:0]                  aux_o
);

  localparam int unsigned QB = FRAC_BITS + 1;
  localparam int unsigned NW = COMP_W + FRAC_BITS + 1;

  // Setup stage: zero length counts as one, numerator gets half the divisor.
  logic [ROOT_W-1:0]        lenc;
  logic [2:0][NW-1:0]       n_d;
  logic [2:0][ROOT_W-1:0]   r0_d;

  always_comb begin
    lenc = (len_i == '0) ? ROOT_W'(1) : len_i;
    for (int i = 0; i < 3; i++) begin
      n_d[i]  = (NW'(m_i[i]) << FRAC_BITS) + NW'(lenc >> 1);
      r0_d[i] = ROOT_W'(n_d[i] >> QB);
    end
  end

  logic                   vld0_q;
  logic [ROOT_W-1:0]      len0_q;
  logic [2:0][NW-1:0]     n0_q;
  logic [2:0][ROOT_W-1:0] r0_q;
  logic [AUX_W-1:0]       aux0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len0_q <= lenc;
      n0_q   <= n_d;
      r0_q   <= r0_d;
      aux0_q <= aux_i;
    end
  end

  logic                   vld_q [QB];
  logic [ROOT_W-1:0]      len_q [QB];
  logic [2:0][NW-1:0]     n_q   [QB];
  logic [2:0][ROOT_W-1:0] r_q   [QB];
  logic [2:0][QB-1:0]     qv_q  [QB];
  logic [AUX_W-1:0]       aux_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic                   vld_in;
    logic [ROOT_W-1:0]      len_in;
    logic [2:0][NW-1:0]     n_in;
    logic [2:0][ROOT_W-1:0] r_in, r_d;
    logic [2:0][QB-1:0]     q_in, q_d;
    logic [AUX_W-1:0]       aux_in;

    if (k == 0) begin : g_first
      assign vld_in = vld0_q;
      assign len_in = len0_q;
      assign n_in   = n0_q;
      assign r_in   = r0_q;
      assign q_in   = '0;
      assign aux_in = aux0_q;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign len_in = len_q[k-1];
      assign n_in   = n_q[k-1];
      assign r_in   = r_q[k-1];
      assign q_in   = qv_q[k-1];
      assign aux_in = aux_q[k-1];
    end

    always_comb begin
      logic [ROOT_W:0] t;
      for (int i = 0; i < 3; i++) begin
        t = {r_in[i], n_in[i][QB-1-k]};
        if (t >= {1'b0, len_in}) begin
          r_d[i] = ROOT_W'(t - {1'b0, len_in});
          q_d[i] = {q_in[i][QB-2:0], 1'b1};
        end else begin
          r_d[i] = t[ROOT_W-1:0];
          q_d[i] = {q_in[i][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[k] <= len_in;
        n_q[k]   <= n_in;
        r_q[k]   <= r_d;
        qv_q[k]  <= q_d;
        aux_q[k] <= aux_in;
      end
    end
  end

  assign valid_o = vld_q[QB-1];
  assign q_o     = qv_q[QB-1];
  assign aux_o   = aux_q[QB-1];

endmodule
`default_nettype wire

/* design/heightfield_normal_top.sv */
// Top level of the heightfield normal pipeline: ports, registers, encoding, output stage.
// Pipeline from input beat to output beat:
// 7 front stages, 32 square root stages, 1 + NORMAL_FRAC_BITS + 1 divider stages, 1 output.
// Throughput: one beat per cycle; the whole pipeline advances whenever the output
// register is empty or its beat is taken, so a stall holds every stage in place.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module heightfield_normal_top import hfn_pkg::*; #(
  parameter int unsigned ELEV_BITS        = 32,
  parameter int unsigned NORMAL_FRAC_BITS = 15
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // center_elev, left_elev, right_elev, top_elev, bottom_elev, edge_mask, zero fill
  input  wire logic [167:0]        s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [47:0]              m_axis_tdata,
  // written
  output logic [0:0]               m_axis_tuser,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CIDX_W-1:0]   cfg_index_i,
  input  wire logic [FIELD_W-1:0]  cfg_data_i
);

  localparam int unsigned QB      = NORMAL_FRAC_BITS + 1;
  localparam int unsigned POS_LIM = ((1 << NORMAL_FRAC_BITS) - 1 > 32767) ?
                                    32767 : (1 << NORMAL_FRAC_BITS) - 1;
  localparam int unsigned NEG_LIM = ((1 << NORMAL_FRAC_BITS) > 32768) ?
                                    32768 : (1 << NORMAL_FRAC_BITS);

  // Configuration registers.
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_grad    <= 32'd65536;
      cfg_q.y_grad    <= 32'd65536;
      cfg_q.flat      <= 32'd65536;
      cfg_q.null_mark <= 32'sh8000_0000;
      cfg_q.null_chk  <= 1'b0;
      cfg_q.zero_msk  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_X_GRAD:    cfg_q.x_grad    <= cfg_data_i;
        CFG_Y_GRAD:    cfg_q.y_grad    <= cfg_data_i;
        CFG_FLAT:      cfg_q.flat      <= cfg_data_i;
        CFG_NULL_MARK: cfg_q.null_mark <= cfg_data_i;
        CFG_NULL_CHK:  cfg_q.null_chk  <= cfg_data_i[0];
        CFG_ZERO_MSK:  cfg_q.zero_msk  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves when the output register can take a beat.
  logic adv;
  logic m_valid_q;

  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  logic             fr_valid;
  logic [SUM_W-1:0] fr_sum;
  norm_aux_t        fr_aux;

  hfn_front #(
    .ELEV_BITS (ELEV_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .valid_i     (s_axis_tvalid),
    .center_i    (s_axis_tdata[31:0]),
    .left_i      (s_axis_tdata[63:32]),
    .right_i     (s_axis_tdata[95:64]),
    .top_i       (s_axis_tdata[127:96]),
    .bottom_i    (s_axis_tdata[159:128]),
    .edge_mask_i (s_axis_tdata[163:160]),
    .cfg_i       (cfg_q),
    .valid_o     (fr_valid),
    .sumsq_o     (fr_sum),
    .aux_o       (fr_aux)
  );

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  norm_aux_t         sq_aux;

  hfn_sqrt #(
    .AUX_W ($bits(norm_aux_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (fr_valid),
    .v_i     (fr_sum),
    .aux_i   (fr_aux),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .aux_o   (sq_aux)
  );

  logic                 dv_valid;
  logic [2:0][QB-1:0]   dv_q;
  flags_t               dv_fl;
  logic [2:0][COMP_W-1:0] dv_m;

  assign dv_m[0] = sq_aux.a;
  assign dv_m[1] = sq_aux.b;
  assign dv_m[2] = sq_aux.f;

  hfn_div #(
    .FRAC_BITS (NORMAL_FRAC_BITS),
    .AUX_W     ($bits(flags_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_valid),
    .m_i     (dv_m),
    .len_i   (sq_root),
    .aux_i   (sq_aux.fl),
    .valid_o (dv_valid),
    .q_o     (dv_q),
    .aux_o   (dv_fl)
  );

  // Clamp the quotient to the code range and apply the sign.
  function automatic logic [OUT_W-1:0] encode(input logic [QB-1:0] q, input logic neg);
    logic [OUT_W:0] qc;
    if (neg) begin
      qc = (32'(q) > NEG_LIM) ? (OUT_W+1)'(NEG_LIM) : (OUT_W+1)'(q);
      return OUT_W'((OUT_W+1)'(0) - qc);
    end
    qc = (32'(q) > POS_LIM) ? (OUT_W+1)'(POS_LIM) : (OUT_W+1)'(q);
    return OUT_W'(qc);
  endfunction

  logic [47:0] m_data_q;
  logic        m_user_q;
  logic [47:0] m_data_d;

  always_comb begin
    if (dv_fl.written) begin
      m_data_d = {encode(dv_q[2], 1'b0), encode(dv_q[1], dv_fl.neg_y),
                  encode(dv_q[0], dv_fl.neg_x)};
    end else begin
      m_data_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_data_q <= m_data_d;
      m_user_q <= dv_fl.written;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

  // A masked cell carries an all-zero normal.
  a_masked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 48'd0)
    else $error("masked cell with nonzero normal");

  // The vertical component is never negative.
  a_z_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[47])
    else $error("negative vertical component");

  // The input side is held exactly when the output beat is stalled.
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow the output stall");

  // A stalled output beat keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output beat changed");

endmodule
`default_nettype wire

/* bench/heightfield_normal_top_test.sv */
// Self-checking bench for the heightfield normal pipeline: table-driven and random cells.
`timescale 1ns / 1ps
module heightfield_normal_top_test;
  import hfn_pkg::*;

  typedef struct {
    logic [31:0] center, left, right, top, bottom;
    logic [3:0]  mask;
    bit          typed;
    logic [15:0] tx, ty, tz;
    bit          tw;
  } cell_t;

  typedef struct {
    logic [15:0] nx, ny, nz;
    bit          written;
  } normal_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_vld = 1'b0;
  logic [167:0] in_data = '0;
  logic         out_rdy = 1'b0;
  logic         cfg_vld = 1'b0;
  cfg_reg_e     cfg_idx = CFG_X_GRAD;
  logic [31:0]  cfg_dat = '0;
  wire          s_rdy, m_vld, cfg_rdy;
  wire [47:0]   m_data;
  wire [0:0]    m_user;

  heightfield_normal_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(in_vld), .s_axis_tready(s_rdy), .s_axis_tdata(in_data),
    .m_axis_tvalid(m_vld), .m_axis_tready(out_rdy), .m_axis_tdata(m_data),
    .m_axis_tuser(m_user),
    .cfg_valid_i(cfg_vld), .cfg_ready_o(cfg_rdy), .cfg_index_i(cfg_idx),
    .cfg_data_i(cfg_dat)
  );

  always #10 clk_i = ~clk_i;

  // Shadow of the register file, updated on each completed write.
  logic [31:0]        sh_xg = 32'd65536, sh_yg = 32'd65536, sh_flat = 32'd65536;
  logic signed [31:0] sh_mark = 32'h8000_0000;
  bit                 sh_chk = 0, sh_zero = 0;

  cell_t   pending[$];
  normal_t normals_due[$];
  int      mismatches = 0;
  int      in_idle = 0, out_idle = 0;

  function automatic int bit_length(logic [127:0] v);
    for (int i = 127; i >= 0; i--) if (v[i]) return i + 1;
    return 0;
  endfunction

  function automatic logic [15:0] to_q15(logic [63:0] m, bit neg, logic [63:0] len);
    logic [63:0] q;
    q = ((m << 15) + len / 2) / len;
    if (neg) begin
      if (q > 64'd32768) q = 64'd32768;
      return 16'(64'd0 - q);
    end
    if (q > 64'd32767) q = 64'd32767;
    return q[15:0];
  endfunction

  function automatic longint side_diff(longint c, longint p, bit hp, longint m, bit hm);
    if (hp && hm) return p - m;
    if (hp) return 2 * (p - c);
    if (hm) return 2 * (c - m);
    return 0;
  endfunction

  function automatic normal_t predict_normal(cell_t c);
    normal_t     res;
    logic [3:0]  m;
    longint      dx, dy;
    logic [127:0] pa, pb;
    logic [63:0] a, b, f, sum, len, cand;
    int          n, s;
    res = '{16'd0, 16'd0, 16'd0, 1'b0};
    m = c.mask;
    if (sh_chk) begin
      if ($signed(c.center) == sh_mark) return res;
      if ($signed(c.top) == sh_mark) m[3] = 0;
      if ($signed(c.bottom) == sh_mark) m[2] = 0;
      if ($signed(c.left) == sh_mark) m[1] = 0;
      if ($signed(c.right) == sh_mark) m[0] = 0;
    end
    if (sh_zero) begin
      if (c.top == 0) m[3] = 0;
      if (c.bottom == 0) m[2] = 0;
      if (c.left == 0) m[1] = 0;
      if (c.right == 0) m[0] = 0;
    end
    if (m == 0) return res;
    dx = side_diff(longint'($signed(c.center)), longint'($signed(c.right)), m[0],
                   longint'($signed(c.left)), m[1]);
    dy = side_diff(longint'($signed(c.center)), longint'($signed(c.bottom)), m[2],
                   longint'($signed(c.top)), m[3]);
    pa = 128'(dx < 0 ? -dx : dx) * 128'(sh_yg);
    pb = 128'(dy < 0 ? -dy : dy) * 128'(sh_xg);
    n = bit_length(pa);
    if (bit_length(pb) > n) n = bit_length(pb);
    if (bit_length(128'(sh_flat)) > n) n = bit_length(128'(sh_flat));
    s = n > 31 ? n - 31 : 0;
    a = 64'(pa >> s);
    b = 64'(pb >> s);
    f = 64'(sh_flat) >> s;
    sum = a * a + b * b + f * f;
    len = 0;
    for (int i = 31; i >= 0; i--) begin
      cand = len | (64'd1 << i);
      if (cand * cand <= sum) len = cand;
    end
    if (len == 0) len = 1;
    res.nx = to_q15(a, dx > 0 && a != 0, len);
    res.ny = to_q15(b, dy < 0 && b != 0, len);
    res.nz = to_q15(f, 1'b0, len);
    res.written = 1'b1;
    return res;
  endfunction

  // Sender: a beat stays up until taken; the next cell may follow in the cycle after it is taken.
  always @(posedge clk_i) begin
    cell_t c;
    normal_t e;
    bit fire;
    fire = 0;
    if (rst_ni) begin
      if (in_vld && s_rdy) begin
        c = pending.pop_front();
        if (c.typed) e = '{c.tx, c.ty, c.tz, c.tw};
        else e = predict_normal(c);
        normals_due.push_back(e);
        fire = 1;
      end
      if (!in_vld || fire) begin
        if (pending.size() > 0 && $urandom_range(99) >= in_idle) begin
          c = pending[0];
          in_vld <= 1'b1;
          in_data <= {4'd0, c.mask, c.bottom, c.top, c.right, c.left, c.center};
        end else begin
          in_vld <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare every normal beat with the oldest prediction.
  always @(posedge clk_i) begin
    normal_t e;
    if (rst_ni) begin
      if (m_vld && out_rdy) begin
        if (normals_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected normal beat %h/%b", m_data, m_user);
        end else begin
          e = normals_due.pop_front();
          if (m_data[15:0] !== e.nx || m_data[31:16] !== e.ny ||
              m_data[47:32] !== e.nz || m_user[0] !== e.written) begin
            mismatches++;
            if (mismatches <= 10)
              $display("normal mismatch: expected x=%h y=%h z=%h w=%b, got x=%h y=%h z=%h w=%b",
                       e.nx, e.ny, e.nz, e.written,
                       m_data[15:0], m_data[31:16], m_data[47:32], m_user[0]);
          end
        end
      end
      out_rdy <= ($urandom_range(99) >= out_idle);
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_vld <= 1'b1;
    cfg_idx <= idx;
    cfg_dat <= val;
    do @(negedge clk_i); while (!cfg_rdy);
    @(posedge clk_i);
    cfg_vld <= 1'b0;
    case (idx)
      CFG_X_GRAD:    sh_xg = val;
      CFG_Y_GRAD:    sh_yg = val;
      CFG_FLAT:      sh_flat = val;
      CFG_NULL_MARK: sh_mark = val;
      CFG_NULL_CHK:  sh_chk = val[0];
      CFG_ZERO_MSK:  sh_zero = val[0];
      default: ;
    endcase
  endtask

  // Waits until every cell is out and the pipeline has had time to empty.
  task automatic drain();
    while (pending.size() != 0 || normals_due.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] xg, yg, fl, mk, bit chk, bit zm);
    write_reg(CFG_X_GRAD, xg);
    write_reg(CFG_Y_GRAD, yg);
    write_reg(CFG_FLAT, fl);
    write_reg(CFG_NULL_MARK, mk);
    write_reg(CFG_NULL_CHK, {31'd0, chk});
    write_reg(CFG_ZERO_MSK, {31'd0, zm});
  endtask

  function automatic logic [31:0] pick_elev(logic [31:0] ctr);
    case ($urandom_range(9))
      0: return sh_mark;
      1: return 32'd0;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4, 5, 6: return ctr + 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random(int count);
    cell_t c;
    repeat (count) begin
      c.center = ($urandom_range(9) == 0) ? sh_mark :
                 ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(100000));
      c.left = pick_elev(c.center);
      c.right = pick_elev(c.center);
      c.top = pick_elev(c.center);
      c.bottom = pick_elev(c.center);
      c.mask = ($urandom_range(3) == 0) ? 4'($urandom) : 4'hF;
      c.typed = 0;
      pending.push_back(c);
    end
  endtask

  localparam int NULL_ROWS = 14;  // rows from here on run with null and zero masking on
  cell_t dir_rows[20];

  initial begin
    // Masked and flat cells have results that are obvious; the rest use the predictor.
    dir_rows[0]  = '{32'd5, 32'd1, 32'd2, 32'd3, 32'd4, 4'h0, 1, 16'd0, 16'd0, 16'd0, 0};
    dir_rows[1]  = '{32'd7, 32'd7, 32'd7, 32'd7, 32'd7, 4'hF, 1, 16'd0, 16'd0, 16'h7FFF, 1};
    dir_rows[2]  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 4'hF, 0, 0, 0, 0, 0};
    dir_rows[3]  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 4'hF, 0, 0, 0, 0, 0};
    dir_rows[4]  = '{32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'd0, 32'd0, 4'h1, 0, 0, 0, 0, 0};
    dir_rows[5]  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 4'h2, 0, 0, 0, 0, 0};
    dir_rows[6]  = '{32'd100, 32'd0, 32'd0, 32'd0, 32'd300, 4'h4, 0, 0, 0, 0, 0};
    dir_rows[7]  = '{32'd100, 32'd0, 32'd0, 32'hFFFF_FF00, 32'd0, 4'h8, 0, 0, 0, 0, 0};
    dir_rows[8]  = '{32'd0, 32'd10, 32'd20, 32'd30, 32'd40, 4'hF, 0, 0, 0, 0, 0};
    dir_rows[9]  = '{32'd0, 32'd10, 32'd20, 32'd30, 32'd40, 4'h5, 0, 0, 0, 0, 0};
    dir_rows[10] = '{32'd0, 32'd10, 32'd20, 32'd30, 32'd40, 4'hA, 0, 0, 0, 0, 0};
    dir_rows[11] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 4'hF, 0, 0, 0, 0, 0};
    dir_rows[12] = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 4'hF, 1, 16'd0, 16'd0, 16'h7FFF, 1};
    dir_rows[13] = '{32'd1, 32'd2, 32'd0, 32'd5, 32'd0, 4'h3, 0, 0, 0, 0, 0};
    // Null center, all neighbors null, all neighbors zero: masked.
    dir_rows[14] = '{32'h8000_0000, 32'd1, 32'd2, 32'd3, 32'd4, 4'hF,
                     1, 16'd0, 16'd0, 16'd0, 0};
    dir_rows[15] = '{32'd9, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     4'hF, 1, 16'd0, 16'd0, 16'd0, 0};
    dir_rows[16] = '{32'd9, 32'd0, 32'd0, 32'd0, 32'd0, 4'hF, 1, 16'd0, 16'd0, 16'd0, 0};
    // Zero center stays; one null and one zero neighbor force mirroring.
    dir_rows[17] = '{32'd0, 32'd5, 32'd8, 32'd2, 32'd9, 4'hF, 0, 0, 0, 0, 0};
    dir_rows[18] = '{32'd50, 32'h8000_0000, 32'd70, 32'd0, 32'd20, 4'hF, 0, 0, 0, 0, 0};
    dir_rows[19] = '{32'd50, 32'd60, 32'h8000_0000, 32'd40, 32'd0, 4'hF, 0, 0, 0, 0, 0};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    in_idle = 8;
    out_idle = 82;
    foreach (dir_rows[i]) begin
      if (i == NULL_ROWS) begin
        drain();
        write_reg(CFG_NULL_CHK, 32'd1);
        write_reg(CFG_ZERO_MSK, 32'd1);
      end
      pending.push_back(dir_rows[i]);
    end
    drain();
    set_regs($urandom, $urandom, $urandom, 32'd12345, 1, 1);
    queue_random(140);
    drain();

    in_idle = 82;
    out_idle = 8;
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 1, 0);
    queue_random(140);
    drain();

    in_idle = 0;
    out_idle = 0;
    set_regs(32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, 0, 1);
    queue_random(130);
    drain();
    set_regs(32'($urandom_range(200000)), 32'($urandom_range(200000)),
             32'($urandom_range(200000)), 32'h8000_0000, 1, 1);
    queue_random(140);
    drain();

    if (mismatches == 0 && normals_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
